/* hdl/stb_pkg.sv */
// Shared types, codes and constants for the software timer bank.
// Used by stb_front, stb_back and software_timer_bank_core; depends on nothing.
package stb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_SLOTS      = 16;
    localparam int MODE_W         = 3;
    localparam int TIME_W         = 32;
    localparam int SLOT_W         = 4;
    localparam int STATUS_W       = 2;
    localparam int IN_TDATA_W     = 72;
    localparam int OUT_TDATA_W    = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_START  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd2;

    localparam logic KIND_FIRE = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Decoded operation handed from the front end to the execution side.
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_START  = 3'd2,
        OP_STOP   = 3'd3,
        OP_DELETE = 3'd4,
        OP_FAIL   = 3'd5
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] period_ms;
        logic              repeat_req;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

endpackage

/* hdl/stb_front.sv */
// Front end of the software timer bank: enable register, item decode and command queue.
// Depends on stb_pkg.
module stb_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [stb_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic [stb_pkg::MODE_W-1:0]     s_tuser,
    output logic                           q_valid,
    output stb_pkg::cmd_t                  q_data,
    input  logic                           q_ready
);

    localparam int PTR_W = (stb_pkg::QUEUE_DEPTH > 1) ? $clog2(stb_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(stb_pkg::QUEUE_DEPTH + 1);

    logic                 enable_reg;
    stb_pkg::cmd_t        queue_mem [stb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    stb_pkg::cmd_t        dec_cmd;
    logic                 dec_keep;
    logic                 push;
    logic                 pop;

    // Disabled ticks and unknown modes are consumed here and never queued.
    always_comb begin
        dec_cmd.now_ms      = s_tdata[31:0];
        dec_cmd.period_ms   = s_tdata[63:32];
        dec_cmd.repeat_req  = s_tdata[64];
        dec_cmd.slot        = s_tdata[68:65];
        dec_cmd.op          = stb_pkg::OP_FAIL;
        dec_keep            = 1'b1;
        case (s_tuser)
            stb_pkg::MODE_TICK: begin
                dec_cmd.op = stb_pkg::OP_TICK;
                dec_keep   = enable_reg;
            end
            stb_pkg::MODE_CREATE: begin
                dec_cmd.op = enable_reg ? stb_pkg::OP_CREATE : stb_pkg::OP_FAIL;
            end
            stb_pkg::MODE_START: begin
                dec_cmd.op = enable_reg ? stb_pkg::OP_START : stb_pkg::OP_FAIL;
            end
            stb_pkg::MODE_STOP: begin
                dec_cmd.op = enable_reg ? stb_pkg::OP_STOP : stb_pkg::OP_FAIL;
            end
            stb_pkg::MODE_DELETE: begin
                dec_cmd.op = enable_reg ? stb_pkg::OP_DELETE : stb_pkg::OP_FAIL;
            end
            default: begin
                dec_keep = 1'b0;
            end
        endcase
    end

    assign s_tready = (count_reg != CNT_W'(stb_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready && dec_keep;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_data   = queue_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(stb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(stb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= dec_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(stb_pkg::QUEUE_DEPTH))
        else $error("command queue count exceeds its depth");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty command queue with unequal pointers");
`endif

endmodule

/* hdl/stb_back.sv */
// Execution side of the software timer bank: slot table, tick scanner and output register.
// Depends on stb_pkg.
module stb_back #(
    parameter int NUM_SLOTS = stb_pkg::MAX_SLOTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  stb_pkg::cmd_t                   q_data,
    output logic                            q_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stb_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              scan_idx_reg, scan_idx_next;
    logic [stb_pkg::TIME_W-1:0]    tick_now_reg, tick_now_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]              pend_slot_reg, pend_slot_next;

    logic                          out_valid_reg;
    logic                          out_kind_reg, out_kind_next;
    logic [stb_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [stb_pkg::SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_load;
    logic                          out_free;

    logic [stb_pkg::TIME_W-1:0]    period_mem [NUM_SLOTS];
    logic [stb_pkg::TIME_W-1:0]    stamp_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]          periodic_reg;
    logic [NUM_SLOTS-1:0]          in_use_reg;
    logic [NUM_SLOTS-1:0]          running_reg;
    logic [NUM_SLOTS-1:0]          kill_reg;

    logic                          free_found;
    logic [IDX_W-1:0]              free_idx;
    logic                          cmd_in_range;
    logic [IDX_W-1:0]              cmd_idx;
    logic [stb_pkg::TIME_W-1:0]    elapsed;
    logic                          slot_fires;
    logic                          last_idx;
    logic                          act_cmd;
    logic                          act_clear;
    logic                          act_fire;

    assign out_free     = !out_valid_reg || m_tready;
    assign cmd_in_range = ({1'b0, q_data.slot} < (stb_pkg::SLOT_W + 1)'(NUM_SLOTS));
    assign cmd_idx      = q_data.slot[IDX_W-1:0];
    assign elapsed      = tick_now_reg - stamp_mem[scan_idx_reg];
    assign slot_fires   = !kill_reg[scan_idx_reg] && running_reg[scan_idx_reg] &&
                          in_use_reg[scan_idx_reg] && (elapsed >= period_mem[scan_idx_reg]);
    assign last_idx     = (scan_idx_reg == IDX_W'(NUM_SLOTS - 1));

    // Lowest free slot for create.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // A firing slot is held back until the next firing or the end of the scan,
    // so that the final fire result of a tick can carry last.
    always_comb begin
        logic step;
        step            = 1'b1;
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        tick_now_next   = tick_now_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        q_ready         = 1'b0;
        out_load        = 1'b0;
        out_kind_next   = stb_pkg::KIND_CMD;
        out_status_next = stb_pkg::STATUS_OK;
        out_slot_next   = '0;
        out_last_next   = 1'b1;
        act_cmd         = 1'b0;
        act_clear       = 1'b0;
        act_fire        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_data.op == stb_pkg::OP_TICK) begin
                        q_ready       = 1'b1;
                        scan_idx_next = '0;
                        tick_now_next = q_data.now_ms;
                        state_next    = ST_SCAN;
                    end else if (out_free) begin
                        q_ready  = 1'b1;
                        act_cmd  = 1'b1;
                        out_load = 1'b1;
                        if (q_data.op == stb_pkg::OP_FAIL) begin
                            out_status_next = stb_pkg::STATUS_DISABLED;
                        end else if (q_data.op == stb_pkg::OP_CREATE) begin
                            if (free_found) begin
                                out_slot_next = stb_pkg::SLOT_W'(free_idx);
                            end else begin
                                out_status_next = stb_pkg::STATUS_NO_SLOT;
                            end
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (kill_reg[scan_idx_reg]) begin
                    act_clear = 1'b1;
                end else if (slot_fires) begin
                    if (pend_valid_reg) begin
                        if (out_free) begin
                            out_load      = 1'b1;
                            out_kind_next = stb_pkg::KIND_FIRE;
                            out_slot_next = stb_pkg::SLOT_W'(pend_slot_reg);
                            out_last_next = 1'b0;
                        end else begin
                            step = 1'b0;
                        end
                    end
                    if (step) begin
                        act_fire        = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_slot_next  = scan_idx_reg;
                    end
                end
                if (step) begin
                    if (last_idx) begin
                        state_next = ST_DRAIN;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    out_kind_next   = stb_pkg::KIND_FIRE;
                    out_slot_next   = stb_pkg::SLOT_W'(pend_slot_reg);
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            in_use_reg     <= '0;
            running_reg    <= '0;
            kill_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (act_cmd) begin
                case (q_data.op)
                    stb_pkg::OP_CREATE: begin
                        if (free_found) begin
                            in_use_reg[free_idx]  <= 1'b1;
                            running_reg[free_idx] <= 1'b0;
                            kill_reg[free_idx]    <= 1'b0;
                        end
                    end
                    stb_pkg::OP_START: begin
                        if (cmd_in_range) begin
                            running_reg[cmd_idx] <= 1'b1;
                        end
                    end
                    stb_pkg::OP_STOP: begin
                        if (cmd_in_range) begin
                            running_reg[cmd_idx] <= 1'b0;
                        end
                    end
                    stb_pkg::OP_DELETE: begin
                        if (cmd_in_range) begin
                            kill_reg[cmd_idx] <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (act_clear) begin
                in_use_reg[scan_idx_reg]  <= 1'b0;
                running_reg[scan_idx_reg] <= 1'b0;
                kill_reg[scan_idx_reg]    <= 1'b0;
            end
            if (act_fire && !periodic_reg[scan_idx_reg]) begin
                running_reg[scan_idx_reg] <= 1'b0;
            end
        end
    end

    // Period, stamp and repeat flag only matter once create has written them.
    always_ff @(posedge aclk) begin
        tick_now_reg  <= tick_now_next;
        pend_slot_reg <= pend_slot_next;
        if (out_load) begin
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_last_reg   <= out_last_next;
        end
        if (act_cmd && (q_data.op == stb_pkg::OP_CREATE) && free_found) begin
            period_mem[free_idx]   <= q_data.period_ms;
            periodic_reg[free_idx] <= q_data.repeat_req;
            stamp_mem[free_idx]    <= q_data.now_ms;
        end
        if (act_cmd && (q_data.op == stb_pkg::OP_START) && cmd_in_range) begin
            stamp_mem[cmd_idx] <= q_data.now_ms;
        end
        if (act_fire && periodic_reg[scan_idx_reg]) begin
            stamp_mem[scan_idx_reg] <= tick_now_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_slot_reg, out_status_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("fire result held while the scanner is idle");

    a_cmd_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == stb_pkg::KIND_CMD)) |-> m_tlast)
        else $error("command response without last");

    a_inner_fire_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !out_last_next) |-> (state_reg == ST_SCAN && pend_valid_reg))
        else $error("non-final fire result outside a tick scan");

    a_no_pop_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !q_ready)
        else $error("command queue popped during a tick scan");
`endif

endmodule

/* hdl/software_timer_bank_core.sv */
// Software timer bank: a table of periodic and one-shot timers driven by timestamped items.
// Top level; instantiates stb_front and stb_back and depends on stb_pkg.
//
// Usage:
//   s_ channel carries one item per transaction: s_tuser holds the mode
//   (tick, create, start, stop, delete), s_tdata the timestamp, interval,
//   repeat flag and slot. cfg_we/cfg_wdata write the enable bit; write it
//   only while the block is idle.
//   m_ channel returns results: m_tuser is 0 for a fired timer and 1 for a
//   command response, m_tdata holds status and slot, m_tlast marks the final
//   result of an item. Every command gives one response; a tick gives one
//   result per firing slot, or none.
// Timing: an accepted command passes through the command queue and the result register
//   and may wait behind a tick scan or a receiver stall. A tick walks the slots one per
//   cycle through the slot table, min(NUM_TIMERS,16) in all, pausing on an output stall.
//   A two-entry command queue accepts up to two more items while a tick is scanned.
// Reset: all slots free and stopped, enable clear, both channels empty.
// A stall on m_tready holds the result register and pauses the scan at the
//   next firing slot; the queue then fills and s_tready drops.
module software_timer_bank_core #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] now_ms, [63:32] period_ms, [64] repeat_req, [68:65] slot
    input  logic [stb_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [2:0] mode
    input  logic [stb_pkg::MODE_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [5:2] result_slot
    output logic [stb_pkg::OUT_TDATA_W-1:0] m_tdata,
    // [0] kind
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int NUM_SLOTS = (NUM_TIMERS < stb_pkg::MAX_SLOTS) ?
                               NUM_TIMERS : stb_pkg::MAX_SLOTS;

    logic          q_valid;
    logic          q_ready;
    stb_pkg::cmd_t q_data;

    stb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_ready   (q_ready)
    );

    stb_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_ready  (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
